// ----- design/psfp_pkg.sv -----
// Shared types, constants and helpers for the particle sensor frame parser.
// Used by psfp_frame_ram, psfp_seq and particle_sensor_frame_parser_core.
`default_nettype none

package psfp_pkg;

   // Frame store size and the widths that follow from it.
   localparam int MAX_FRAME_BYTES = 40;
   localparam int MIN_FRAME_BYTES = 8;
   localparam int ADDR_W          = $clog2(MAX_FRAME_BYTES);
   localparam int LEN_W           = $clog2(MAX_FRAME_BYTES + 1);

   // Frame layout: header word, length word, data words, trailer word.
   localparam int   FIRST_DATA_BYTE = 4;
   localparam int   OVERHEAD_WORDS  = 3;
   localparam int   LEN_WORD_BIAS   = 4;
   localparam int   MAX_RESULTS     = 17;
   localparam logic [7:0]  START_BYTE  = 8'h42;
   localparam logic [15:0] HEADER_WORD = 16'h424D;

   // Byte positions of the header and length words.
   localparam logic [ADDR_W-1:0] POS_HDR_HI = ADDR_W'(0);
   localparam logic [ADDR_W-1:0] POS_HDR_LO = ADDR_W'(1);
   localparam logic [ADDR_W-1:0] POS_LEN_HI = ADDR_W'(2);
   localparam logic [ADDR_W-1:0] POS_LEN_LO = ADDR_W'(3);

   // Configuration register.
   localparam int              CSR_ADDR_W        = 2;
   localparam int              CSR_DATA_W        = 32;
   localparam int              FRAME_BYTES_W     = 6;
   localparam logic [5:0]      FRAME_BYTES_RESET = 6'd32;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_BYTES_ADDR = '0;

   // Result status codes.
   localparam logic [2:0] STAT_OK         = 3'd0;
   localparam logic [2:0] STAT_BAD_HEADER = 3'd1;
   localparam logic [2:0] STAT_BAD_LENGTH = 3'd2;
   localparam logic [2:0] STAT_CHECKSUM   = 3'd3;
   localparam logic [2:0] STAT_DUPLICATE  = 3'd4;

   // One result item.
   typedef struct packed {
      logic [15:0] word_value;
      logic [4:0]  word_index;
      logic [2:0]  status;
      logic        last;
   } psfp_res_type;

   // Frame store access from the sequencer.
   typedef struct packed {
      logic              wen;
      logic [ADDR_W-1:0] waddr;
      logic [7:0]        wdata;
      logic              ren;
      logic [ADDR_W-1:0] raddr;
   } psfp_ram_req_type;

   // Effective frame length: even, at least the minimum, at most the store size.
   function automatic logic [LEN_W-1:0] eff_len(input logic [FRAME_BYTES_W-1:0] fb);
      logic [7:0] len;
      len = {2'b00, fb[FRAME_BYTES_W-1:1], 1'b0};
      if (len < 8'(MIN_FRAME_BYTES)) begin
         len = 8'(MIN_FRAME_BYTES);
      end
      if (len > 8'(MAX_FRAME_BYTES & ~1)) begin
         len = 8'(MAX_FRAME_BYTES & ~1);
      end
      return len[LEN_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- design/psfp_frame_ram.sv -----
// Frame store: one write port and one registered read port.
// Depends on psfp_pkg for the depth and the access struct.
`default_nettype none

module psfp_frame_ram (
   input  logic                       clock,
   input  psfp_pkg::psfp_ram_req_type ram_req,
   output logic [7:0]                 rd_data
);
   import psfp_pkg::*;

   logic [7:0] mem_ff [0:MAX_FRAME_BYTES-1];
   logic [7:0] rd_data_ff;

   // Byte write during frame collection.
   always_ff @(posedge clock) begin
      if (ram_req.wen) begin
         mem_ff[ram_req.waddr] <= ram_req.wdata;
      end
   end

   // Registered read; data holds until the next read.
   always_ff @(posedge clock) begin
      if (ram_req.ren) begin
         rd_data_ff <= mem_ff[ram_req.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- design/psfp_seq.sv -----
// Sequencer: byte intake, checksum sweep over the frame store, frame checks
// and word emission. Depends on psfp_pkg; drives psfp_frame_ram.
`default_nettype none

module psfp_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [7:0]                  req_rx_byte,
   input  logic [psfp_pkg::LEN_W-1:0]  frame_len,
   output psfp_pkg::psfp_ram_req_type  ram_req,
   input  logic [7:0]                  rd_data,
   input  logic                        out_free,
   output logic                        push,
   output psfp_pkg::psfp_res_type      res
);
   import psfp_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_TRL_A,
      ST_TRL_B,
      ST_CHECK,
      ST_EMIT_A,
      ST_EMIT_B,
      ST_EMIT_C
   } state_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [LEN_W-1:0]  flen_ff, flen_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;
   logic              sum_pend_ff, sum_pend_in;
   logic [15:0]       sum_ff, sum_in;
   logic [15:0]       last_sum_ff, last_sum_in;
   logic [7:0]        hdr_hi_ff, hdr_hi_in;
   logic [7:0]        hdr_lo_ff, hdr_lo_in;
   logic [7:0]        len_hi_ff, len_hi_in;
   logic [7:0]        len_lo_ff, len_lo_in;
   logic [7:0]        trl_hi_ff, trl_hi_in;
   logic [7:0]        word_hi_ff, word_hi_in;
   logic [4:0]        idx_ff, idx_in;

   logic [7:0]        pos_next;
   logic [LEN_W-1:0]  sum_end;
   logic [LEN_W-1:0]  trl_addr_hi;
   logic [LEN_W-1:0]  trl_addr_lo;
   logic [7:0]        words;
   logic [7:0]        shown;
   logic [4:0]        last_idx;
   logic [7:0]        data_addr;
   logic [7:0]        data_addr_lo;
   logic [16:0]       len_check;
   logic [2:0]        check_status;

   assign req_ready = (state_ff == ST_IDLE);

   // Frame geometry derived from the latched length.
   assign pos_next     = 8'(pos_ff) + 8'd1;
   assign sum_end      = flen_ff - LEN_W'(OVERHEAD_WORDS);
   assign trl_addr_hi  = flen_ff - LEN_W'(2);
   assign trl_addr_lo  = flen_ff - LEN_W'(1);
   assign words        = 8'(flen_ff >> 1) - 8'(OVERHEAD_WORDS);
   assign shown        = (words > 8'(MAX_RESULTS)) ? 8'(MAX_RESULTS) : words;
   assign last_idx     = 5'(shown - 8'd1);
   assign data_addr    = 8'(FIRST_DATA_BYTE) + {2'b00, idx_ff, 1'b0};
   assign data_addr_lo = data_addr + 8'd1;
   assign len_check    = {1'b0, len_hi_ff, len_lo_ff} + 17'(LEN_WORD_BIAS);

   // Frame checks in priority order; the trailer low byte is on the read port.
   always_comb begin
      if ({hdr_hi_ff, hdr_lo_ff} != HEADER_WORD) begin
         check_status = STAT_BAD_HEADER;
      end else if (len_check != 17'(flen_ff)) begin
         check_status = STAT_BAD_LENGTH;
      end else if (sum_ff != {trl_hi_ff, rd_data}) begin
         check_status = STAT_CHECKSUM;
      end else if (sum_ff == last_sum_ff) begin
         check_status = STAT_DUPLICATE;
      end else begin
         check_status = STAT_OK;
      end
   end

   // Next-state logic.
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      flen_in      = flen_ff;
      cnt_in       = cnt_ff;
      pend_addr_in = cnt_ff[ADDR_W-1:0];
      sum_pend_in  = (state_ff == ST_SUM);
      sum_in       = sum_ff;
      last_sum_in  = last_sum_ff;
      hdr_hi_in    = hdr_hi_ff;
      hdr_lo_in    = hdr_lo_ff;
      len_hi_in    = len_hi_ff;
      len_lo_in    = len_lo_ff;
      trl_hi_in    = trl_hi_ff;
      word_hi_in   = word_hi_ff;
      idx_in       = idx_ff;
      ram_req      = '0;
      push         = 1'b0;
      res          = '0;

      // The adder accumulates each swept byte in the cycle after its read.
      if (sum_pend_ff) begin
         sum_in = sum_ff + {8'h00, rd_data};
         case (pend_addr_ff)
            POS_HDR_HI: hdr_hi_in = rd_data;
            POS_HDR_LO: hdr_lo_in = rd_data;
            POS_LEN_HI: len_hi_in = rd_data;
            POS_LEN_LO: len_lo_in = rd_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            // Collect bytes; drop everything until the start byte while hunting.
            if (req_valid && ((pos_ff != '0) || (req_rx_byte == START_BYTE))) begin
               ram_req.wen   = 1'b1;
               ram_req.waddr = pos_ff;
               ram_req.wdata = req_rx_byte;
               if (pos_next >= 8'(frame_len)) begin
                  pos_in   = '0;
                  flen_in  = frame_len;
                  cnt_in   = '0;
                  sum_in   = '0;
                  state_in = ST_SUM;
               end else begin
                  pos_in = pos_next[ADDR_W-1:0];
               end
            end
         end
         ST_SUM: begin
            // Sweep every byte ahead of the trailer word.
            ram_req.ren   = 1'b1;
            ram_req.raddr = cnt_ff[ADDR_W-1:0];
            cnt_in        = cnt_ff + LEN_W'(1);
            if (cnt_ff == sum_end) begin
               state_in = ST_TRL_A;
            end
         end
         ST_TRL_A: begin
            ram_req.ren   = 1'b1;
            ram_req.raddr = trl_addr_hi[ADDR_W-1:0];
            state_in      = ST_TRL_B;
         end
         ST_TRL_B: begin
            ram_req.ren   = 1'b1;
            ram_req.raddr = trl_addr_lo[ADDR_W-1:0];
            trl_hi_in     = rd_data;
            state_in      = ST_CHECK;
         end
         ST_CHECK: begin
            // A failed check gives one error result; a good frame starts emission.
            if (check_status == STAT_OK) begin
               last_sum_in = sum_ff;
               idx_in      = '0;
               state_in    = ST_EMIT_A;
            end else if (out_free) begin
               push       = 1'b1;
               res.status = check_status;
               res.last   = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_EMIT_A: begin
            ram_req.ren   = 1'b1;
            ram_req.raddr = data_addr[ADDR_W-1:0];
            state_in      = ST_EMIT_B;
         end
         ST_EMIT_B: begin
            ram_req.ren   = 1'b1;
            ram_req.raddr = data_addr_lo[ADDR_W-1:0];
            word_hi_in    = rd_data;
            state_in      = ST_EMIT_C;
         end
         ST_EMIT_C: begin
            // Hand the word over once the output register can take it.
            if (out_free) begin
               push           = 1'b1;
               res.word_value = {word_hi_ff, rd_data};
               res.word_index = idx_ff;
               res.status     = STAT_OK;
               res.last       = (idx_ff == last_idx);
               if (idx_ff == last_idx) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 5'd1;
                  state_in = ST_EMIT_A;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and working registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         pos_ff      <= '0;
         sum_pend_ff <= 1'b0;
         last_sum_ff <= '0;
      end else begin
         state_ff    <= state_in;
         pos_ff      <= pos_in;
         sum_pend_ff <= sum_pend_in;
         last_sum_ff <= last_sum_in;
      end
      flen_ff      <= flen_in;
      cnt_ff       <= cnt_in;
      pend_addr_ff <= pend_addr_in;
      sum_ff       <= sum_in;
      hdr_hi_ff    <= hdr_hi_in;
      hdr_lo_ff    <= hdr_lo_in;
      len_hi_ff    <= len_hi_in;
      len_lo_ff    <= len_lo_in;
      trl_hi_ff    <= trl_hi_in;
      word_hi_ff   <= word_hi_in;
      idx_ff       <= idx_in;
   end

`ifndef ASSERT_OFF
   // The frame store is written only while collecting bytes.
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_req.wen |-> (state_ff == ST_IDLE))
      else $error("frame store written outside collection");

   // A result is produced only when the output register can take it.
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      push |-> out_free)
      else $error("result pushed into a full output register");

   // The final result of a frame returns the sequencer to collection.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (push && res.last) |=> (state_ff == ST_IDLE))
      else $error("sequencer busy after final result");

   // Processing a frame always starts from a cleared byte position.
   a_pos_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (pos_ff == '0))
      else $error("byte position not cleared during frame processing");

   // Emitted word indexes never pass the last shown word.
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (push && (res.status == STAT_OK)) |-> (res.word_index <= last_idx))
      else $error("word index beyond the frame");
`endif

endmodule

`default_nettype wire

// ----- design/particle_sensor_frame_parser_core.sv -----
// Top level of the particle sensor frame parser: configuration register,
// output register, frame store and sequencer. Depends on psfp_pkg,
// psfp_frame_ram and psfp_seq.
//
//   Channel   Ports                          Direction  Payload
//   req       req_valid / req_ready          in         req_rx_byte
//   rsp       rsp_valid / rsp_ready          out        rsp_word_value, rsp_word_index,
//                                                       rsp_status, rsp_last
//   csr       psel / penable / pwrite        in         paddr, pwdata, prdata
//
// A byte that does not finish a frame leaves req_ready high for the next byte.
// The byte that finishes a frame of L bytes starts a sweep of its first L-2 bytes through the
// single read port of the frame store, then the two trailer reads and the checks, then the
// emission of the data words of a good frame, held back while rsp_ready is low.
// Reset is synchronous and active high; the frame store needs no clearing.
// The last result of a frame waits in the output register while new bytes are taken.
`default_nettype none

module particle_sensor_frame_parser_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_rx_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [15:0]                         rsp_word_value,
   output logic [4:0]                          rsp_word_index,
   output logic [2:0]                          rsp_status,
   output logic                                rsp_last,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [psfp_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [psfp_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [psfp_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);
   import psfp_pkg::*;

   logic [FRAME_BYTES_W-1:0] frame_bytes_ff, frame_bytes_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   psfp_res_type             rsp_res_ff, rsp_res_in;
   logic [LEN_W-1:0]         frame_len;
   psfp_ram_req_type         ram_req;
   logic [7:0]               rd_data;
   logic                     out_free;
   logic                     push;
   psfp_res_type             res;
   logic                     csr_write;

   // Configuration port: one register, every address in the window selects it.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && (paddr == paddr);
   assign prdata    = CSR_DATA_W'(frame_bytes_ff);
   assign frame_len = eff_len(frame_bytes_ff);

   always_comb begin
      frame_bytes_in = frame_bytes_ff;
      if (csr_write) begin
         frame_bytes_in = pwdata[FRAME_BYTES_W-1:0];
      end
   end

   // Output register; a new result may load in the cycle the old one transfers.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_bytes_ff <= FRAME_BYTES_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         frame_bytes_ff <= frame_bytes_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_word_value = rsp_res_ff.word_value;
   assign rsp_word_index = rsp_res_ff.word_index;
   assign rsp_status     = rsp_res_ff.status;
   assign rsp_last       = rsp_res_ff.last;

   // Frame store.
   psfp_frame_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   // Intake, checksum sweep, checks and word emission.
   psfp_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .frame_len   (frame_len),
      .ram_req     (ram_req),
      .rd_data     (rd_data),
      .out_free    (out_free),
      .push        (push),
      .res         (res)
   );

endmodule

`default_nettype wire

// ----- bench/psfp_result_checker.sv -----
// Result checker for the particle sensor frame parser: follows every byte
// transfer and register write, predicts the frame words and compares them.
// Depends on psfp_pkg for the result type, status codes and frame constants.
`timescale 1ns / 1ps

module psfp_result_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [7:0]                      req_rx_byte,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [15:0]                     rsp_word_value,
   input  logic [4:0]                      rsp_word_index,
   input  logic [2:0]                      rsp_status,
   input  logic                            rsp_last,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [psfp_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [psfp_pkg::CSR_DATA_W-1:0] pwdata,
   input  logic [psfp_pkg::CSR_DATA_W-1:0] prdata,
   input  logic                            pready,
   output int                              mismatch_total,
   output int                              words_pending
);
   import psfp_pkg::*;

   // Mirror of the parser state and of the frame length register.
   logic [7:0]               byte_store [MAX_FRAME_BYTES];
   logic [5:0]               fill_pos;
   logic [15:0]              accepted_sum;
   logic [FRAME_BYTES_W-1:0] frame_bytes_reg;
   psfp_res_type             words_due [$];
   int                       mismatches = 0;

   assign mismatch_total = mismatches;

   // Frame length in force for a register value: even, clamped to the store.
   function automatic int frame_span(input logic [FRAME_BYTES_W-1:0] fb);
      int n;
      n = int'({fb[FRAME_BYTES_W-1:1], 1'b0});
      if (n < MIN_FRAME_BYTES) begin
         n = MIN_FRAME_BYTES;
      end
      if (n > (MAX_FRAME_BYTES & ~1)) begin
         n = MAX_FRAME_BYTES & ~1;
      end
      return n;
   endfunction

   // Big-endian word from two stored bytes.
   function automatic logic [15:0] stored_word(input int pos);
      return {byte_store[pos], byte_store[pos + 1]};
   endfunction

   // A rejected frame gives a single word carrying only its status.
   function automatic psfp_res_type error_word(input logic [2:0] code);
      psfp_res_type r;
      r.word_value = '0;
      r.word_index = '0;
      r.status     = code;
      r.last       = 1'b1;
      return r;
   endfunction

   task automatic flag_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) begin
         $display("[%0t] mismatch: %s", $realtime, what);
      end
   endtask

   // A complete frame: checks run in a fixed order, the first failure wins.
   task automatic close_frame(input int len);
      logic [15:0]  sum;
      int           words;
      psfp_res_type r;
      sum = '0;
      for (int i = 0; i + 2 < len; i++) begin
         sum = sum + 16'(byte_store[i]);
      end
      if (stored_word(0) != HEADER_WORD) begin
         words_due.push_back(error_word(STAT_BAD_HEADER));
      end else if (int'(stored_word(2)) + LEN_WORD_BIAS != len) begin
         words_due.push_back(error_word(STAT_BAD_LENGTH));
      end else if (sum != stored_word(len - 2)) begin
         words_due.push_back(error_word(STAT_CHECKSUM));
      end else if (sum == accepted_sum) begin
         words_due.push_back(error_word(STAT_DUPLICATE));
      end else begin
         words = len / 2 - OVERHEAD_WORDS;
         if (words > MAX_RESULTS) begin
            words = MAX_RESULTS;
         end
         for (int i = 0; i < words; i++) begin
            r.word_value = stored_word(FIRST_DATA_BYTE + 2 * i);
            r.word_index = 5'(i);
            r.status     = STAT_OK;
            r.last       = (i == words - 1);
            words_due.push_back(r);
         end
         accepted_sum = sum;
      end
   endtask

   // One byte transfer: hunt for the start byte, then collect a frame.
   task automatic take_byte(input logic [7:0] b);
      int len;
      len = frame_span(frame_bytes_reg);
      if (fill_pos == '0 && b != START_BYTE) begin
         return;
      end
      if (fill_pos < MAX_FRAME_BYTES) begin
         byte_store[fill_pos] = b;
      end
      fill_pos = fill_pos + 6'd1;
      if (int'(fill_pos) >= len) begin
         fill_pos = '0;
         close_frame(len);
      end
   endtask

   // One result transfer against the oldest predicted word.
   task automatic check_word();
      psfp_res_type want;
      if (words_due.size() == 0) begin
         flag_mismatch($sformatf("unexpected word value %h index %0d status %0d last %b",
                                 rsp_word_value, rsp_word_index, rsp_status, rsp_last));
         return;
      end
      want = words_due.pop_front();
      if (rsp_word_value !== want.word_value || rsp_word_index !== want.word_index ||
          rsp_status !== want.status || rsp_last !== want.last) begin
         flag_mismatch($sformatf(
            "expected value %h index %0d status %0d last %b, got %h %0d %0d %b",
            want.word_value, want.word_index, want.status, want.last,
            rsp_word_value, rsp_word_index, rsp_status, rsp_last));
      end
   endtask

   // Sample every transfer at the clock edge that completes it. A byte taken
   // at the same edge as a register write still sees the old frame length.
   always @(posedge clock) begin
      if (reset) begin
         fill_pos        = '0;
         accepted_sum    = '0;
         frame_bytes_reg = FRAME_BYTES_RESET;
         words_due.delete();
         foreach (byte_store[i]) begin
            byte_store[i] = '0;
         end
      end else begin
         if (req_valid && req_ready) begin
            take_byte(req_rx_byte);
         end
         if (psel && penable && pready && paddr == CSR_FRAME_BYTES_ADDR) begin
            if (pwrite) begin
               frame_bytes_reg = pwdata[FRAME_BYTES_W-1:0];
            end else if (prdata[FRAME_BYTES_W-1:0] !== frame_bytes_reg) begin
               flag_mismatch($sformatf("frame length read back %0d, expected %0d",
                                       prdata[FRAME_BYTES_W-1:0], frame_bytes_reg));
            end
         end
         if (rsp_valid && rsp_ready) begin
            check_word();
         end
      end
      words_pending <= words_due.size();
   end

endmodule

// ----- bench/particle_sensor_frame_parser_core_test.sv -----
// Testbench top for particle_sensor_frame_parser_core: sends sensor frames and
// register writes with random idling on both channels and gives the verdict.
// Depends on psfp_pkg, the core and psfp_result_checker.
`timescale 1ns / 1ps

module particle_sensor_frame_parser_core_test;
   import psfp_pkg::*;

   localparam int ITEM_TARGET   = 410;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 60;
   localparam int CYCLE_LIMIT   = 600000;

   typedef enum int {
      FR_GOOD,
      FR_REPEAT,
      FR_BAD_HEADER,
      FR_BAD_LENGTH,
      FR_BAD_SUM,
      FR_CUT,
      FR_NOISE
   } frame_kind_type;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   logic [7:0]            req_rx_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   logic [15:0]           rsp_word_value;
   logic [4:0]            rsp_word_index;
   logic [2:0]            rsp_status;
   logic                  rsp_last;
   logic                  psel        = 1'b0;
   logic                  penable     = 1'b0;
   logic                  pwrite      = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr       = '0;
   logic [CSR_DATA_W-1:0] pwdata      = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int                    mismatch_total;
   int                    words_pending;

   // Stimulus state.
   logic       sender_steady   = 1'b0;
   logic       receiver_steady = 1'b0;
   logic       hold_off        = 1'b0;
   int         cur_len         = 32;
   int         items_sent      = 0;
   int         cycle_count     = 0;
   logic [7:0] frame_q [$];
   logic [7:0] last_good_q [$];

   particle_sensor_frame_parser_core u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_word_value (rsp_word_value),
      .rsp_word_index (rsp_word_index),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   psfp_result_checker u_result_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_word_value (rsp_word_value),
      .rsp_word_index (rsp_word_index),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .mismatch_total (mismatch_total),
      .words_pending  (words_pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Run limit in clock cycles.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Idle stretch: mostly short, sometimes medium, rarely long.
   function automatic int idle_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 80) begin
         return $urandom_range(1, 3);
      end
      if (p < 95) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // Register values at and past the ends of the legal frame length.
   function automatic logic [FRAME_BYTES_W-1:0] corner_fb(input int k);
      case (k)
         0: return 6'd8;
         1: return 6'd40;
         2: return 6'd0;
         3: return 6'd63;
         4: return 6'd9;
         5: return 6'd41;
         6: return 6'd7;
         default: return 6'd62;
      endcase
   endfunction

   // Result side: random stalls, plus one long hold-off on request.
   initial begin : rsp_drive
      int   run;
      logic hold_seen;
      hold_seen = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off && !hold_seen) begin
            hold_seen = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (!receiver_steady && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            run = idle_len();
            repeat (run) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // One byte transfer, then an optional gap on the input side.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      gap = 0;
      if (!sender_steady && $urandom_range(0, 1) == 1) begin
         gap = idle_len();
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop sending and wait until every predicted word has been seen.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= CSR_FRAME_BYTES_ADDR;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Write the frame length with the block idle, then read it back.
   task automatic set_frame_bytes(input logic [FRAME_BYTES_W-1:0] fb);
      settle();
      csr_access(1'b1, {26'($urandom), fb});
      csr_access(1'b0, '0);
      cur_len = int'({fb[FRAME_BYTES_W-1:1], 1'b0});
      if (cur_len < MIN_FRAME_BYTES) begin
         cur_len = MIN_FRAME_BYTES;
      end
      if (cur_len > MAX_FRAME_BYTES) begin
         cur_len = MAX_FRAME_BYTES;
      end
   endtask

   // Assemble the bytes of one frame of the current length.
   task automatic build_frame(input frame_kind_type kind);
      logic [15:0] w;
      logic [15:0] sum;
      frame_q.delete();
      if (kind == FR_NOISE) begin
         frame_q.push_back($urandom_range(0, 1) ? START_BYTE : 8'($urandom));
         repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom));
      end else if (kind == FR_REPEAT && last_good_q.size() == cur_len) begin
         frame_q = last_good_q;
      end else begin
         frame_q.push_back(START_BYTE);
         w = HEADER_WORD;
         if (kind == FR_BAD_HEADER) begin
            w[7:0] = 8'($urandom);
            if (w[7:0] == HEADER_WORD[7:0]) begin
               w[7:0] = ~w[7:0];
            end
         end
         frame_q.push_back(w[7:0]);
         w = 16'(cur_len - LEN_WORD_BIAS);
         if (kind == FR_BAD_LENGTH) begin
            w = w ^ (16'd1 << $urandom_range(0, 15));
         end
         frame_q.push_back(w[15:8]);
         frame_q.push_back(w[7:0]);
         for (int i = 0; i < cur_len / 2 - OVERHEAD_WORDS; i++) begin
            case ($urandom_range(0, 7))
               0: w = 16'h0000;
               1: w = 16'hFFFF;
               default: w = 16'($urandom);
            endcase
            frame_q.push_back(w[15:8]);
            frame_q.push_back(w[7:0]);
         end
         sum = '0;
         foreach (frame_q[i]) begin
            sum = sum + 16'(frame_q[i]);
         end
         if (kind == FR_BAD_SUM) begin
            sum = sum ^ (16'd1 << $urandom_range(0, 15));
         end
         frame_q.push_back(sum[15:8]);
         frame_q.push_back(sum[7:0]);
         if (kind == FR_GOOD || kind == FR_REPEAT) begin
            last_good_q = frame_q;
         end
      end
   endtask

   // Send one frame; cut frames and noise are followed by zeros to bring the parser
   // back to hunting, since zeros are dropped there.
   task automatic send_frame(input frame_kind_type kind);
      int cut;
      build_frame(kind);
      cut = frame_q.size();
      if (kind == FR_CUT) begin
         cut = $urandom_range(1, frame_q.size() - 1);
      end
      for (int i = 0; i < cut; i++) begin
         send_byte(frame_q[i]);
      end
      items_sent += cut;
      if (kind == FR_CUT || kind == FR_NOISE) begin
         repeat (cur_len) send_byte(8'h00);
      end
   endtask

   initial begin : stimulus
      frame_kind_type kind;
      int             pick;
      int             fb;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: bytes dropped while hunting, every status, length corners.
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(FR_GOOD);
      send_frame(FR_REPEAT);
      send_frame(FR_BAD_HEADER);
      send_frame(FR_BAD_LENGTH);
      send_frame(FR_BAD_SUM);
      for (int k = 0; k < 8; k++) begin
         set_frame_bytes(corner_fb(k));
         send_frame(FR_GOOD);
      end

      // Length cut below the bytes already held: the frame closes at once.
      set_frame_bytes(6'd32);
      build_frame(FR_GOOD);
      for (int i = 0; i < 20; i++) begin
         send_byte(frame_q[i]);
      end
      set_frame_bytes(6'd8);
      send_byte(frame_q[20]);
      repeat (cur_len) send_byte(8'h00);

      // Length raised in the middle of a frame built for the longer length.
      set_frame_bytes(6'd16);
      build_frame(FR_GOOD);
      set_frame_bytes(6'd8);
      for (int i = 0; i < 4; i++) begin
         send_byte(frame_q[i]);
      end
      set_frame_bytes(6'd16);
      for (int i = 4; i < frame_q.size(); i++) begin
         send_byte(frame_q[i]);
      end

      // Back pressure: the result side holds off while short frames keep coming.
      set_frame_bytes(6'd8);
      sender_steady = 1'b1;
      hold_off      = 1'b1;
      repeat (8) send_frame(FR_GOOD);
      sender_steady = 1'b0;

      // Random phases, each with its own frame length and idling mode.
      while (items_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            fb = $urandom_range(8, 16);
         end else if (pick < 85) begin
            fb = $urandom_range(17, 40);
         end else begin
            fb = corner_fb($urandom_range(0, 7));
         end
         set_frame_bytes(6'(fb));
         sender_steady   = ($urandom_range(0, 4) == 0);
         receiver_steady = ($urandom_range(0, 4) == 0);
         repeat ($urandom_range(3, 8)) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
               kind = FR_GOOD;
            end else if (pick < 72) begin
               kind = FR_REPEAT;
            end else if (pick < 78) begin
               kind = FR_BAD_HEADER;
            end else if (pick < 84) begin
               kind = FR_BAD_LENGTH;
            end else if (pick < 90) begin
               kind = FR_BAD_SUM;
            end else if (pick < 95) begin
               kind = FR_CUT;
            end else begin
               kind = FR_NOISE;
            end
            send_frame(kind);
         end
      end

      settle();
      if (mismatch_total == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
